// ===== hw/rtl/tcaoq_pkg.sv =====
// Shared types and constants for the two-class age-ordered queue.
// No dependencies.
package tcaoq_pkg;

  localparam int TAG_W           = 16;
  localparam int STAMP_W         = 8;
  localparam int CLASS_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    REQ_ENQ     = 2'd0,
    REQ_DEQ_ANY = 2'd1,
    REQ_DEQ_CAT = 2'd2,
    REQ_DEQ_DOG = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // One stored entry: tag and arrival stamp.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Pointer update command to one class FIFO.
  typedef struct packed {
    logic push;
    logic pop;
  } ptr_cmd_t;

  // Occupancy flags of one class FIFO.
  typedef struct packed {
    logic empty;
    logic full;
  } ptr_stat_t;

endpackage

// ===== hw/rtl/tcaoq_class_mem.sv =====
// Entry storage for one class: one write port, one read port,
// registered read data. Depends on tcaoq_pkg.
module tcaoq_class_mem
  import tcaoq_pkg::*;
#(
  parameter int DEPTH = CLASS_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tcaoq_fifo_ptr.sv =====
// Head, tail and fill count of one class FIFO, wrapping at DEPTH.
// Depends on tcaoq_pkg.
module tcaoq_fifo_ptr
  import tcaoq_pkg::*;
#(
  parameter int DEPTH = CLASS_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  ptr_cmd_t      cmd,
  output logic [AW-1:0] head,
  output logic [AW-1:0] tail,
  output ptr_stat_t     stat
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.push) begin
        tail <= (tail == LAST) ? '0 : tail + 1'b1;
      end
      if (cmd.pop) begin
        head <= (head == LAST) ? '0 : head + 1'b1;
      end
      if (cmd.push && !cmd.pop) begin
        count <= count + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));

endmodule

// ===== hw/rtl/two_class_age_ordered_queue.sv =====
// Top level of the two-class age-ordered queue.
// Depends on tcaoq_pkg, tcaoq_class_mem and tcaoq_fifo_ptr.
//
// A request is taken on a rising edge with start high and busy low. At the
// accept edge both class memories are read at their head pointers. That
// read is registered, so the decision (enqueue write, age compare, pop)
// happens in the following cycle, while busy is high. The one result for
// the request is on the ports with done high for exactly one cycle, the
// cycle after the execute cycle. There is no back-pressure: the result is
// taken at the rising edge that ends the done cycle, and it is gone after
// that edge. A new request may be accepted at that same edge, but not
// while the last one is still executing. Status: ok, empty (nothing of the
// requested class, or nothing at all), or full (the enqueue was refused).
// out_tag and out_class are zero unless an item was removed. Dequeue-any
// takes the head with the greater modular age (next_stamp - stamp,
// mod 256); equal ages go to class 0 (cat).
module two_class_age_ordered_queue
  import tcaoq_pkg::*;
#(
  parameter int CLASS_DEPTH = CLASS_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type,
  input  logic             item_class,
  input  logic [TAG_W-1:0] item_tag,
  output logic             done,
  output logic [1:0]       status,
  output logic [TAG_W-1:0] out_tag,
  output logic             out_class
);

  localparam int AW = $clog2(CLASS_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t             state;
  req_t               req_q;
  logic               class_q;
  logic [TAG_W-1:0]   tag_q;
  logic [STAMP_W-1:0] next_stamp;

  // Per-class FIFO plumbing
  ptr_cmd_t      cmd  [2];
  ptr_stat_t     stat [2];
  logic [AW-1:0] head [2];
  logic [AW-1:0] tail [2];
  entry_t        rd   [2];
  entry_t        wdata;

  // Decision made in the execute cycle
  logic               take;
  logic               sel;
  logic [STAMP_W-1:0] age0;
  logic [STAMP_W-1:0] age1;
  logic [STAMP_W-1:0] next_stamp_next;
  status_t            res_status;
  logic [TAG_W-1:0]   res_tag;
  logic               res_class;

  assign wdata = '{tag: tag_q, stamp: next_stamp};

  for (genvar c = 0; c < 2; c++) begin : g_class
    tcaoq_fifo_ptr #(
      .DEPTH (CLASS_DEPTH),
      .AW    (AW)
    ) u_ptr (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd[c]),
      .head (head[c]),
      .tail (tail[c]),
      .stat (stat[c])
    );

    // Read port always follows head; heads are stable from accept to
    // execute, so the registered data is the head entry in ST_EXEC.
    tcaoq_class_mem #(
      .DEPTH (CLASS_DEPTH),
      .AW    (AW)
    ) u_mem (
      .clk   (clk),
      .we    (cmd[c].push),
      .waddr (tail[c]),
      .wdata (wdata),
      .raddr (head[c]),
      .rdata (rd[c])
    );
  end

  // Modular age of each head; larger is older.
  assign age0 = next_stamp - rd[0].stamp;
  assign age1 = next_stamp - rd[1].stamp;

  always_comb begin
    cmd[0]          = '0;
    cmd[1]          = '0;
    take            = 1'b0;
    sel             = 1'b0;
    next_stamp_next = next_stamp;
    res_status      = STAT_OK;
    res_tag         = '0;
    res_class       = 1'b0;
    if (state == ST_EXEC) begin
      case (req_q)
        REQ_ENQ: begin
          if (stat[class_q].full) begin
            res_status = STAT_FULL;   // refused, nothing changes
          end else begin
            cmd[class_q].push = 1'b1;
            next_stamp_next   = next_stamp + 1'b1;
          end
        end
        REQ_DEQ_ANY: begin
          if (!stat[0].empty && !stat[1].empty) begin
            take = 1'b1;
            sel  = (age0 < age1);     // tie goes to class 0
          end else if (!stat[0].empty) begin
            take = 1'b1;
          end else if (!stat[1].empty) begin
            take = 1'b1;
            sel  = 1'b1;
          end
        end
        default: begin
          sel  = (req_q == REQ_DEQ_DOG);
          take = !stat[sel].empty;
        end
      endcase
      if (take) begin
        cmd[sel].pop = 1'b1;
        res_tag      = rd[sel].tag;
        res_class    = sel;
      end else if (req_q != REQ_ENQ) begin
        res_status = STAT_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      next_stamp <= '0;
    end else begin
      done <= (state == ST_EXEC);
      case (state)
        ST_IDLE: begin
          if (start) begin
            state   <= ST_EXEC;
            req_q   <= req_t'(req_type);
            class_q <= item_class;
            tag_q   <= item_tag;
          end
        end
        ST_EXEC: begin
          state      <= ST_IDLE;
          next_stamp <= next_stamp_next;
          status     <= res_status;
          out_tag    <= res_tag;
          out_class  <= res_class;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state == ST_EXEC);

`ifndef NO_ASSERTIONS
  // A result only ever follows an execute cycle.
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("done without a preceding execute cycle");

  // Every accepted request is executed in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_EXEC))
    else $error("accepted request not executed");

  // Never write into a full class FIFO.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !((cmd[0].push && stat[0].full) || (cmd[1].push && stat[1].full)))
    else $error("push into full class FIFO");

  // Never remove from an empty class FIFO.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !((cmd[0].pop && stat[0].empty) || (cmd[1].pop && stat[1].empty)))
    else $error("pop from empty class FIFO");

  // At most one FIFO moves per request.
  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd[0].push, cmd[0].pop, cmd[1].push, cmd[1].pop}) <= 1)
    else $error("more than one FIFO update in one request");
`endif

endmodule

// ===== tb/sv/two_class_age_ordered_queue_tb.sv =====
// Self-checking testbench for two_class_age_ordered_queue (one request, one result).
// Depends on tcaoq_pkg and the two_class_age_ordered_queue RTL with its submodules.
`timescale 1ns / 100ps

module two_class_age_ordered_queue_tb;
  import tcaoq_pkg::*;

  localparam int DEPTH       = CLASS_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;

  // One request waiting to be driven. A hold entry carries no request: the
  // driver parks on it until every owed result has come back.
  typedef struct {
    req_t             rq;
    logic             cls;
    logic [TAG_W-1:0] tag;
    int               gap;
    bit               hold;
  } shelter_req_t;

  // What the block must answer for one request.
  typedef struct {
    status_t          st;
    logic [TAG_W-1:0] tag;
    logic             cls;
  } outcome_t;

  // One resident of a class line: its tag and arrival stamp.
  typedef struct {
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } resident_t;

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             start      = 1'b0;
  logic [1:0]       req_type   = 2'd0;
  logic             item_class = 1'b0;
  logic [TAG_W-1:0] item_tag   = '0;
  logic             busy;
  logic             done;
  logic [1:0]       status;
  logic [TAG_W-1:0] out_tag;
  logic             out_class;

  // Stimulus and scoreboard state
  shelter_req_t request_backlog[$];
  outcome_t     awaited_results[$];
  resident_t    cat_line[$];
  resident_t    dog_line[$];
  logic [STAMP_W-1:0] arrival_ctr = '0;

  shelter_req_t cur_req;
  bit           holding     = 1'b0;
  int           gap_left    = 0;
  logic         took        = 1'b0;   // transfer happened at the last rising edge
  int           err_count   = 0;
  int           cycle_count = 0;
  int           gap_run_left = 0;
  bit           no_gaps     = 1'b0;

  two_class_age_ordered_queue dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .item_class (item_class),
    .item_tag   (item_tag),
    .done       (done),
    .status     (status),
    .out_tag    (out_tag),
    .out_class  (out_class)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: two class lines with arrival stamps, one outcome per request.
  // ---------------------------------------------------------------------------
  function automatic outcome_t release_head(logic cls);
    outcome_t  r;
    resident_t who;
    if (cls) who = dog_line.pop_front();
    else     who = cat_line.pop_front();
    r.st  = STAT_OK;
    r.tag = who.tag;
    r.cls = cls;
    return r;
  endfunction

  function automatic outcome_t serve_request(req_t rq, logic cls, logic [TAG_W-1:0] tag);
    outcome_t           r;
    resident_t          fresh;
    logic [STAMP_W-1:0] cat_age;
    logic [STAMP_W-1:0] dog_age;
    r.st  = STAT_EMPTY;
    r.tag = '0;
    r.cls = 1'b0;
    case (rq)
      REQ_ENQ: begin
        if ((cls ? dog_line.size() : cat_line.size()) >= DEPTH) begin
          r.st = STAT_FULL;             // refused, nothing moves
        end else begin
          fresh.tag   = tag;
          fresh.stamp = arrival_ctr;
          if (cls) dog_line.push_back(fresh);
          else     cat_line.push_back(fresh);
          arrival_ctr = arrival_ctr + 1'b1;
          r.st = STAT_OK;
        end
      end
      REQ_DEQ_ANY: begin
        if (cat_line.size() != 0 && dog_line.size() != 0) begin
          // modular age; ties go to the cat line
          cat_age = arrival_ctr - cat_line[0].stamp;
          dog_age = arrival_ctr - dog_line[0].stamp;
          r = release_head(cat_age >= dog_age ? 1'b0 : 1'b1);
        end else if (cat_line.size() != 0) begin
          r = release_head(1'b0);
        end else if (dog_line.size() != 0) begin
          r = release_head(1'b1);
        end
      end
      REQ_DEQ_CAT: if (cat_line.size() != 0) r = release_head(1'b0);
      REQ_DEQ_DOG: if (dog_line.size() != 0) r = release_head(1'b1);
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders. Idle gaps come in runs: some runs are back-to-back,
  // others draw 0..13 idle cycles per request.
  // ---------------------------------------------------------------------------
  task automatic queue_req(req_t rq, logic cls, logic [TAG_W-1:0] tag);
    shelter_req_t p;
    if (gap_run_left == 0) begin
      no_gaps      = ($urandom_range(0, 2) == 0);
      gap_run_left = $urandom_range(20, 80);
    end
    gap_run_left--;
    p.rq   = rq;
    p.cls  = cls;
    p.tag  = tag;
    p.gap  = no_gaps ? 0 : $urandom_range(0, 13);
    p.hold = 1'b0;
    request_backlog.push_back(p);
  endtask

  // dequeue with junk in the ignored fields
  task automatic queue_deq(req_t rq);
    queue_req(rq, 1'($urandom_range(0, 1)), 16'($urandom));
  endtask

  task automatic queue_hold();
    shelter_req_t p;
    p.rq   = REQ_ENQ;
    p.cls  = 1'b0;
    p.tag  = '0;
    p.gap  = 0;
    p.hold = 1'b1;
    request_backlog.push_back(p);
  endtask

  function automatic logic [TAG_W-1:0] pick_tag();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Park a cat at the head, push 'spacing' - 1 stamps through the dog line, then
  // land a dog whose stamp is 'spacing' later. 256 aliases to a tie (cat wins);
  // 255 makes the younger dog look older once the stamp wraps.
  task automatic queue_stamp_wrap(int spacing);
    int left;
    int batch;
    repeat (DEPTH) queue_deq(REQ_DEQ_CAT);
    repeat (DEPTH) queue_deq(REQ_DEQ_DOG);
    queue_req(REQ_ENQ, 1'b0, pick_tag());
    left = spacing - 1;
    while (left > 0) begin
      batch = $urandom_range(1, left < DEPTH ? left : DEPTH);
      repeat (batch) queue_req(REQ_ENQ, 1'b1, pick_tag());
      repeat (batch) queue_deq(REQ_DEQ_DOG);
      left -= batch;
    end
    queue_req(REQ_ENQ, 1'b1, pick_tag());
    queue_deq(REQ_DEQ_ANY);
    queue_deq(REQ_DEQ_ANY);
    queue_deq(REQ_DEQ_ANY);
  endtask

  task automatic build_stimulus();
    int bias;
    int enq_pct;
    bit fav;
    // Directed: empty dequeues of every kind, tag extremes, age order.
    queue_deq(REQ_DEQ_ANY);
    queue_deq(REQ_DEQ_CAT);
    queue_deq(REQ_DEQ_DOG);
    queue_req(REQ_ENQ, 1'b0, 16'h0000);
    queue_req(REQ_ENQ, 1'b1, 16'hFFFF);
    queue_req(REQ_ENQ, 1'b1, 16'h5A5A);
    queue_req(REQ_ENQ, 1'b0, 16'hFFFF);
    queue_deq(REQ_DEQ_ANY);
    queue_deq(REQ_DEQ_ANY);
    queue_deq(REQ_DEQ_DOG);
    queue_deq(REQ_DEQ_DOG);
    queue_deq(REQ_DEQ_CAT);
    queue_deq(REQ_DEQ_ANY);
    queue_hold();

    // Fill both lines to refusal, check a refused enqueue changes nothing,
    // then drain through dequeue-any until empty.
    repeat (DEPTH + 1) queue_req(REQ_ENQ, 1'b0, pick_tag());
    repeat (DEPTH + 1) queue_req(REQ_ENQ, 1'b1, pick_tag());
    queue_deq(REQ_DEQ_ANY);
    queue_req(REQ_ENQ, 1'b1, pick_tag());
    queue_req(REQ_ENQ, 1'b0, pick_tag());
    repeat (2 * DEPTH + 1) queue_deq(REQ_DEQ_ANY);
    queue_hold();

    // Stamp wraparound: exact tie and aliased order.
    queue_stamp_wrap(256);
    queue_hold();
    queue_stamp_wrap(255);

    // Random mix; phases lean toward filling, draining or neither so that
    // both full and empty lines come up often.
    for (int i = 0; i < 650; i++) begin
      if (i % 40 == 0) begin
        bias = $urandom_range(0, 2);
        fav  = 1'($urandom_range(0, 1));
      end
      enq_pct = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;
      if ($urandom_range(0, 99) < enq_pct)
        queue_req(REQ_ENQ, ($urandom_range(0, 3) == 0) ? !fav : fav, pick_tag());
      else
        queue_deq(req_t'($urandom_range(1, 3)));
      if ($urandom_range(0, 149) == 0) queue_hold();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: inputs move on the falling edge. start stays up until a transfer
  // is seen; a zero gap loads the next request without dropping start.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic go;
    if (!rst) begin
      go = start;
      if (start && took) go = 1'b0;
      if (!go && !holding && request_backlog.size() != 0) begin
        cur_req  = request_backlog.pop_front();
        holding  = 1'b1;
        gap_left = cur_req.gap;
      end
      if (!go && holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cur_req.hold) begin
          if (awaited_results.size() == 0) holding = 1'b0;
        end else begin
          req_type   <= cur_req.rq;
          item_class <= cur_req.cls;
          item_tag   <= cur_req.tag;
          go         = 1'b1;
          holding    = 1'b0;
        end
      end
      start <= go;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on each rising edge, check a result if done is up, then predict
  // for a request transfer. No back-pressure on results, so done is one cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      took <= 1'b0;
    end else begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result with none owed: status=%0d tag=%h class=%0d",
                                    status, out_tag, out_class));
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.st)
            report_mismatch($sformatf("status %0d, want %0d", status, want.st));
          if (out_tag !== want.tag)
            report_mismatch($sformatf("out_tag %h, want %h", out_tag, want.tag));
          if (out_class !== want.cls)
            report_mismatch($sformatf("out_class %0d, want %0d", out_class, want.cls));
        end
      end
      if (start && !busy)
        awaited_results.push_back(serve_request(req_t'(req_type), item_class, item_tag));
      took <= start && !busy;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("two_class_age_ordered_queue regression: fail");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // wait for every request to be taken and every result to come back
    while (request_backlog.size() != 0 || holding || start || awaited_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("two_class_age_ordered_queue regression: pass");
    else
      $display("two_class_age_ordered_queue regression: fail");
    $finish;
  end

endmodule
